// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked at every rising edge, held off while reset is active (low).
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/gpe_pkg.sv =====
package gpe_pkg;

    localparam int GlyphCols  = 5;
    localparam int CellCols   = 6;
    localparam int CellRows   = 8;
    localparam int StoreAddrW = 11;
    localparam int CoordW     = 12;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [10:0] glyph_addr;
        logic [7:0]  glyph_byte;
        logic [6:0]  pos_x;
        logic [6:0]  pos_y;
        logic [7:0]  char_code;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic [7:0]  scale;
    } t_in_item;

    typedef struct packed {
        logic [11:0] op_x;
        logic [11:0] op_y;
        logic [7:0]  op_size;
        logic [15:0] op_color;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic                  en;
        logic [StoreAddrW-1:0] addr;
        logic [7:0]            data;
    } t_store_wr;

endpackage

// ===== hdl/gpe_if.sv =====
interface gpe_in_if;
    import gpe_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gpe_out_if;
    import gpe_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/gpe_ram.sv =====
module gpe_ram #(
    parameter int Width = 8,
    parameter int Depth = 1280,
    parameter int AddrW = $clog2(Depth)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gpe_raster.sv =====
module gpe_raster #(
    parameter int DISPLAY_WIDTH = 128,
    parameter int GLYPH_CODES   = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gpe_in_if.sink                        i_px,
    gpe_out_if.source                     o_sq,
    output gpe_pkg::t_store_wr            o_wr,
    output logic [gpe_pkg::StoreAddrW-1:0] o_raddr,
    input  logic [7:0]                    i_rdata
);
    import gpe_pkg::*;

    localparam int StoreDepth = GLYPH_CODES * GlyphCols;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LATCH,
        S_ROW,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [2:0]  r_col;
    logic [2:0]  r_row;
    logic [CoordW-1:0] r_x;
    logic [CoordW-1:0] r_y;
    logic [7:0]  r_bits;
    logic [6:0]  r_py;
    logic [7:0]  r_code;
    logic [15:0] r_fg;
    logic [15:0] r_bg;
    logic [7:0]  r_sc;
    logic        r_pv;
    t_out_item   r_pend;
    logic        r_ov;
    t_out_item   r_out;

    logic              in_xfer;
    logic              clipped;
    logic              code_ok;
    logic [CoordW-1:0] add_a;
    logic [CoordW-1:0] add_sum;
    logic              cand;
    logic [15:0]       cand_color;
    logic              out_free;
    logic              stall;
    logic              out_load;
    t_out_item         pend_last;

    assign in_xfer = i_px.valid && i_px.ready;
    assign clipped = (CoordW'(i_px.data.pos_x) + CoordW'(8)) >= CoordW'(DISPLAY_WIDTH);
    assign code_ok = 9'(r_code) < 9'(GLYPH_CODES);

    // Glyph store writes come straight from a load transfer.
    assign o_wr.en   = in_xfer && (i_px.data.cmd == CMD_LOAD)
                       && (i_px.data.glyph_addr < StoreAddrW'(StoreDepth));
    assign o_wr.addr = i_px.data.glyph_addr;
    assign o_wr.data = i_px.data.glyph_byte;

    // code * 5 + column
    assign o_raddr = StoreAddrW'({r_code, 2'b00}) + StoreAddrW'(r_code) + StoreAddrW'(r_col);

    // Single adder: column step in FETCH, row step in ROW.
    assign add_a   = (r_state == S_FETCH) ? r_x : r_y;
    assign add_sum = add_a + CoordW'(r_sc);

    assign cand       = r_bits[0] || (r_fg != r_bg);
    assign cand_color = r_bits[0] ? r_fg : r_bg;
    assign out_free   = !r_ov || o_sq.ready;
    // One result is held back so the final one can be marked last.
    assign stall      = cand && r_pv && !out_free;

    // Held square moves to the output register mid-scan or at the end of the scan.
    assign out_load = ((r_state == S_ROW) && !stall && cand && r_pv)
                      || ((r_state == S_DONE) && r_pv && out_free);

    always_comb begin
        pend_last      = r_pend;
        pend_last.last = 1'b1;
    end

    assign i_px.ready = (r_state == S_IDLE);
    assign o_sq.valid = r_ov;
    assign o_sq.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_sq.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_px.data.cmd == CMD_DRAW) && !clipped) begin
                        r_x     <= CoordW'(i_px.data.pos_x);
                        r_py    <= i_px.data.pos_y;
                        r_code  <= i_px.data.char_code;
                        r_fg    <= i_px.data.fg_color;
                        r_bg    <= i_px.data.bg_color;
                        r_sc    <= (i_px.data.scale == 8'd0) ? 8'd1 : i_px.data.scale;
                        r_col   <= 3'd0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    if (r_col != 3'd0) begin
                        r_x <= add_sum;
                    end
                    r_state <= S_LATCH;
                end
                S_LATCH: begin
                    r_bits  <= ((r_col < 3'(GlyphCols)) && code_ok) ? i_rdata : 8'd0;
                    r_y     <= CoordW'(r_py);
                    r_row   <= 3'd0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    if (!stall) begin
                        if (cand) begin
                            r_pend.op_x     <= r_x;
                            r_pend.op_y     <= r_y;
                            r_pend.op_size  <= r_sc;
                            r_pend.op_color <= cand_color;
                            r_pend.last     <= 1'b0;
                            r_pv            <= 1'b1;
                            if (r_pv) begin
                                r_out <= r_pend;
                            end
                        end
                        r_y    <= add_sum;
                        r_bits <= {1'b0, r_bits[7:1]};
                        r_row  <= r_row + 3'd1;
                        if (r_row == 3'(CellRows - 1)) begin
                            if (r_col == 3'(CellCols - 1)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_col   <= r_col + 3'd1;
                                r_state <= S_FETCH;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_pv) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out   <= pend_last;
                        r_pv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/glyph_pixel_expander.sv =====
// Rasterizes 5x8 bitmap-font characters into filled squares. Load transfers
// (cmd 0) write one column byte of the glyph store if glyph_addr is inside
// it; the store has no reset, so every entry a draw will read must be loaded
// first. A draw transfer (cmd 1) scans six columns (five glyph columns plus a
// blank spacing column) by eight rows and emits one square per dot: set dots
// in the foreground color, clear dots in the background color unless both
// colors are equal. The final square of a character carries last. A character
// whose pos_x + 8 reaches DISPLAY_WIDTH is dropped and the block stays ready.
// An unclipped draw occupies the block until its scan ends, and longer under
// output back-pressure: per column the FETCH state does the column step and
// store address, LATCH takes the registered store read, then ROW steps the
// eight rows through the single coordinate adder; at the end DONE flushes the
// held last square. Input ready is low for the whole draw; the output register
// lets the last square wait while the next item is taken.
module glyph_pixel_expander #(
    parameter int DISPLAY_WIDTH = 128,
    parameter int GLYPH_CODES   = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpe_in_if.sink    i_px,
    gpe_out_if.source o_sq
);
    import gpe_pkg::*;

    `include "assert_macros.svh"

    localparam int StoreDepth = GLYPH_CODES * GlyphCols;
    localparam int RamAddrW   = $clog2(StoreDepth);

    t_store_wr             st_wr;
    logic [StoreAddrW-1:0] st_raddr;
    logic [7:0]            st_rdata;

    gpe_raster #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .GLYPH_CODES   (GLYPH_CODES)
    ) u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (i_px),
        .o_sq    (o_sq),
        .o_wr    (st_wr),
        .o_raddr (st_raddr),
        .i_rdata (st_rdata)
    );

    gpe_ram #(
        .Width (8),
        .Depth (StoreDepth),
        .AddrW (RamAddrW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_wr.en),
        .i_waddr (st_wr.addr[RamAddrW-1:0]),
        .i_wdata (st_wr.data),
        .i_raddr (st_raddr[RamAddrW-1:0]),
        .o_rdata (st_rdata)
    );

    `ASSERT_SYNC(a_wr_on_load, i_clk, i_rst_n, st_wr.en |-> (i_px.valid && i_px.ready && (i_px.data.cmd == CMD_LOAD)), "store write without load transfer")
    `ASSERT_SYNC(a_load_stays_ready, i_clk, i_rst_n, (i_px.valid && i_px.ready && (i_px.data.cmd == CMD_LOAD)) |=> i_px.ready, "load left the idle state")
    `ASSERT_SYNC(a_size_nonzero, i_clk, i_rst_n, o_sq.valid |-> (o_sq.data.op_size != 8'd0), "square of zero size")

endmodule

// ===== verif/gpe_square_monitor.sv =====
`timescale 1ns / 100ps

module gpe_square_monitor
    import gpe_pkg::*;
#(
    parameter int DISPLAY_WIDTH = 128,
    parameter int GLYPH_CODES   = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gpe_in_if    i_px,
    gpe_out_if   i_sq,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int StoreDepth = GLYPH_CODES * GlyphCols;

    logic [7:0] glyph_copy [StoreDepth];
    t_out_item  squares_due [$];
    int         mismatches = 0;

    // Queue every square one character cell should produce, in scan order.
    task automatic rasterize(input t_in_item it);
        int unsigned sc;
        int unsigned n;
        logic [7:0]  bits;
        t_out_item   sq;
        n = 0;
        if (int'(it.pos_x) + 8 >= DISPLAY_WIDTH) begin
            return;
        end
        sc = (it.scale == 8'd0) ? 1 : int'(it.scale);
        for (int unsigned col = 0; col < CellCols; col++) begin
            bits = 8'h00;
            if (col < GlyphCols && int'(it.char_code) < GLYPH_CODES) begin
                bits = glyph_copy[int'(it.char_code) * GlyphCols + col];
            end
            for (int unsigned row = 0; row < CellRows; row++) begin
                sq.op_x    = 12'(int'(it.pos_x) + col * sc);
                sq.op_y    = 12'(int'(it.pos_y) + row * sc);
                sq.op_size = 8'(sc);
                sq.last    = 1'b0;
                if (bits[row]) begin
                    sq.op_color = it.fg_color;
                    squares_due.push_back(sq);
                    n++;
                end else if (it.bg_color != it.fg_color) begin
                    sq.op_color = it.bg_color;
                    squares_due.push_back(sq);
                    n++;
                end
            end
        end
        if (n > 0) begin
            squares_due[squares_due.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (i_px.valid && i_px.ready) begin
                if (i_px.data.cmd == CMD_LOAD) begin
                    if (int'(i_px.data.glyph_addr) < StoreDepth) begin
                        glyph_copy[i_px.data.glyph_addr] = i_px.data.glyph_byte;
                    end
                end else begin
                    rasterize(i_px.data);
                end
            end
            if (i_sq.valid && i_sq.ready) begin
                got = i_sq.data;
                if (squares_due.size() == 0) begin
                    $error("unexpected square transfer: x %0d y %0d size %0d color %h",
                           got.op_x, got.op_y, got.op_size, got.op_color);
                    mismatches++;
                end else begin
                    want = squares_due.pop_front();
                    if (got.op_x != want.op_x) begin
                        $error("op_x: expected %0d, got %0d", want.op_x, got.op_x);
                        mismatches++;
                    end
                    if (got.op_y != want.op_y) begin
                        $error("op_y: expected %0d, got %0d", want.op_y, got.op_y);
                        mismatches++;
                    end
                    if (got.op_size != want.op_size) begin
                        $error("op_size: expected %0d, got %0d", want.op_size, got.op_size);
                        mismatches++;
                    end
                    if (got.op_color != want.op_color) begin
                        $error("op_color: expected %h, got %h", want.op_color, got.op_color);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= squares_due.size();
    end

endmodule

// ===== verif/tb_glyph_pixel_expander.sv =====
`timescale 1ns / 100ps

module tb_glyph_pixel_expander;
    import gpe_pkg::*;

    localparam int DisplayWidth = 128;
    localparam int GlyphCodes   = 256;
    localparam int StoreDepth   = GlyphCodes * GlyphCols;
    localparam int ItemTarget   = 210;
    localparam int CycleLimit   = 400000;
    localparam int HoldAfter    = 150;
    localparam int HoldCycles   = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gpe_in_if  px_bus ();
    gpe_out_if sq_bus ();

    int fail_count;
    int pending;
    int cycles = 0;
    int sent   = 0;
    bit calm   = 1'b0;

    bit             addr_loaded [StoreDepth];
    bit             code_listed [GlyphCodes];
    logic [7:0]     drawable [$];

    glyph_pixel_expander #(
        .DISPLAY_WIDTH(DisplayWidth),
        .GLYPH_CODES  (GlyphCodes)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_px   (px_bus),
        .o_sq   (sq_bus)
    );

    gpe_square_monitor #(
        .DISPLAY_WIDTH(DisplayWidth),
        .GLYPH_CODES  (GlyphCodes)
    ) u_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_px        (px_bus),
        .i_sq        (sq_bus),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("tb_glyph_pixel_expander NOT OK");
            $finish;
        end
    end

    function automatic t_in_item random_item();
        t_in_item it;
        it.cmd        = 1'($urandom);
        it.glyph_addr = 11'($urandom);
        it.glyph_byte = 8'($urandom);
        it.pos_x      = 7'($urandom);
        it.pos_y      = 7'($urandom);
        it.char_code  = 8'($urandom);
        it.fg_color   = 16'($urandom);
        it.bg_color   = 16'($urandom);
        it.scale      = 8'($urandom);
        return it;
    endfunction

    // One transfer on the pixel channel, with an occasional idle burst ahead of it.
    task automatic send_item(input t_in_item it);
        int  code;
        bit  full;
        if (!calm && $urandom_range(0, 3) == 0) begin
            px_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        px_bus.valid <= 1'b1;
        px_bus.data  <= it;
        do @(posedge i_clk); while (!px_bus.ready);
        sent++;
        if (it.cmd == CMD_LOAD && int'(it.glyph_addr) < StoreDepth) begin
            addr_loaded[it.glyph_addr] = 1'b1;
            code = int'(it.glyph_addr) / GlyphCols;
            full = 1'b1;
            for (int c = 0; c < GlyphCols; c++) begin
                full &= addr_loaded[code * GlyphCols + c];
            end
            // only fully loaded codes may be drawn
            if (full && !code_listed[code]) begin
                code_listed[code] = 1'b1;
                drawable.push_back(8'(code));
            end
        end
    endtask

    task automatic load_byte(input int addr, input logic [7:0] b);
        t_in_item it;
        it            = random_item();
        it.cmd        = CMD_LOAD;
        it.glyph_addr = 11'(addr);
        it.glyph_byte = b;
        send_item(it);
    endtask

    task automatic draw_char(input logic [7:0] code, input int px, input int py,
                             input logic [15:0] fg, input logic [15:0] bg,
                             input logic [7:0] sc);
        t_in_item it;
        it           = random_item();
        it.cmd       = CMD_DRAW;
        it.char_code = code;
        it.pos_x     = 7'(px);
        it.pos_y     = 7'(py);
        it.fg_color  = fg;
        it.bg_color  = bg;
        it.scale     = sc;
        send_item(it);
    endtask

    initial begin : square_sink
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        sq_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sq_bus.valid && sq_bus.ready) begin
                taken++;
            end
            if (!held && taken >= HoldAfter) begin
                // long stall so the block backs up into its input
                held = 1'b1;
                sq_bus.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                sq_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                sq_bus.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int          pick;
        int          code;
        int          px;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [7:0]  sc;

        i_rst_n      <= 1'b0;
        px_bus.valid <= 1'b0;
        px_bus.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // code 0: mixed column patterns; code 1: blank; code 255: top of the store
        load_byte(0, 8'hFF);
        load_byte(1, 8'h00);
        load_byte(2, 8'h01);
        load_byte(3, 8'h80);
        load_byte(4, 8'hAA);
        for (int c = 0; c < GlyphCols; c++) begin
            load_byte(GlyphCols + c, 8'h00);
        end
        load_byte(StoreDepth - 5, 8'h55);
        load_byte(StoreDepth - 4, 8'hFE);
        load_byte(StoreDepth - 3, 8'h7F);
        load_byte(StoreDepth - 2, 8'($urandom));
        load_byte(StoreDepth - 1, 8'($urandom));
        // loads past the store are dropped
        load_byte(StoreDepth, 8'hFF);
        load_byte(2047, 8'hFF);

        draw_char(8'd0, 0, 0, 16'hF800, 16'h001F, 8'd0);
        draw_char(8'd255, DisplayWidth - 9, 127, 16'hFFFF, 16'h0000, 8'd255);
        draw_char(8'd0, 10, 20, 16'h07E0, 16'h07E0, 8'd1);
        draw_char(8'd1, 30, 40, 16'h1234, 16'h1234, 8'd2);
        draw_char(8'd1, 50, 60, 16'hABCD, 16'h5432, 8'd3);
        draw_char(8'd0, DisplayWidth - 8, 5, 16'hFFFF, 16'h0000, 8'd1);
        draw_char(8'd255, 127, 127, 16'h0001, 16'h8000, 8'd4);

        while (sent < ItemTarget) begin
            if (sent >= ItemTarget - 30) begin
                calm = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                code = $urandom_range(0, GlyphCodes - 1);
                for (int c = 0; c < GlyphCols; c++) begin
                    load_byte(code * GlyphCols + c, 8'($urandom));
                end
            end else if (pick < 25) begin
                load_byte($urandom_range(StoreDepth, 2047), 8'($urandom));
            end else begin
                code = drawable[$urandom_range(0, drawable.size() - 1)];
                px = ($urandom_range(0, 99) < 15) ? $urandom_range(DisplayWidth - 8, 127)
                                                  : $urandom_range(0, DisplayWidth - 9);
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    sc = 8'($urandom_range(1, 4));
                end else if (pick < 85) begin
                    sc = 8'($urandom);
                end else begin
                    sc = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
                end
                fg = 16'($urandom);
                bg = ($urandom_range(0, 99) < 20) ? fg : 16'($urandom);
                draw_char(8'(code), px, $urandom_range(0, 127), fg, bg, sc);
            end
        end
        px_bus.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_glyph_pixel_expander OK");
        end else begin
            $display("tb_glyph_pixel_expander NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/gpe_pkg.sv
hdl/gpe_if.sv
hdl/gpe_ram.sv
hdl/gpe_raster.sv
hdl/glyph_pixel_expander.sv
verif/gpe_square_monitor.sv
verif/tb_glyph_pixel_expander.sv
